### rtl/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types and constants of the box versus frustum culling test: the
// request and result structs, plane packing and the cull class codes.
// ----------------------------------------------------------------------------
`default_nettype none

package afc_pkg;

    // Coordinate width of a box center; the extent is one bit narrower.
    localparam int COORD_WIDTH      = 16;
    // Fraction bits of a plane normal component.
    localparam int NORMAL_FRAC_BITS = 14;
    // Number of frustum planes.
    localparam int PLANES           = 6;
    // Width of one packed plane field and of a whole plane register.
    localparam int NORM_W           = 16;
    localparam int PLANE_W          = 4 * NORM_W;
    // Index width of the register write port.
    localparam int CFG_IDX_W        = 3;

    // Width of one product, and of the distance and limit comparison.
    localparam int PROD_W  = COORD_WIDTH + NORM_W;
    localparam int SUM_A_W = PROD_W + 3;
    localparam int SUM_B_W = NORM_W + NORMAL_FRAC_BITS + 1;
    localparam int CMP_W   = (SUM_A_W > SUM_B_W) ? SUM_A_W : SUM_B_W;

    // Cull class codes.
    localparam logic [1:0] CLASS_OUTSIDE    = 2'd0;
    localparam logic [1:0] CLASS_INSIDE     = 2'd1;
    localparam logic [1:0] CLASS_INTERSECTS = 2'd2;

    // One box request.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] box_center_x;
        logic signed [COORD_WIDTH-1:0] box_center_y;
        logic signed [COORD_WIDTH-1:0] box_center_z;
        logic        [COORD_WIDTH-2:0] box_extent_x;
        logic        [COORD_WIDTH-2:0] box_extent_y;
        logic        [COORD_WIDTH-2:0] box_extent_z;
    } afc_box_t;

    // One cull result.
    typedef struct packed {
        logic       visible;
        logic [1:0] cull_class;
    } afc_result_t;

endpackage

`default_nettype wire

### rtl/aabb_frustum_cull_test.sv
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test
// Tests axis-aligned boxes against six frustum planes, one box per clock.
// ----------------------------------------------------------------------------
// Usage:
//   Software writes the six planes through wr_en / wr_index / wr_data while
//   no box is in flight. Each plane packs normal x, y, z (signed Q1.14) and a
//   signed integer offset, 16 bits each from the low end. Writes to an index
//   above five are dropped.
//   A box request is taken at each rising edge where start is high and busy
//   is low. busy is always low: the pipeline takes a new box every clock.
//   After a request is taken, done is high for one cycle with the
//   result: visible, and cull_class (outside, inside or intersects).
//   Throughput is one box per clock; the five register stages are input
//   capture, the 36 parallel products (one multiplier per path), the
//   per-plane distance and radius sums, the per-plane compares, and the
//   final merge.
//   Reset clears all planes to zero, so every box then tests as inside, and
//   empties the pipeline. The receiver cannot stall; results are not held.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_frustum_cull_test
    import afc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Box requests.
    input  wire logic                  start,
    output logic                       busy,
    input  wire afc_box_t              box,
    // Results.
    output logic                       done,
    output afc_result_t                result,
    // Plane register writes.
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [PLANE_W-1:0]    wr_data
);

    // Plane registers.
    logic [PLANE_W-1:0] plane_reg [PLANES];

    // Pipeline valid bits.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, done_reg;

    // Stage payloads.
    afc_box_t                 box_reg;
    logic signed [PROD_W-1:0] dprod_reg  [PLANES][3];
    logic signed [PROD_W-1:0] rprod_reg  [PLANES][3];
    logic signed [PROD_W-1:0] dprod_next [PLANES][3];
    logic signed [PROD_W-1:0] rprod_next [PLANES][3];
    logic signed [CMP_W-1:0]  dist_reg   [PLANES];
    logic signed [CMP_W-1:0]  rad_reg    [PLANES];
    logic signed [CMP_W-1:0]  lim_reg    [PLANES];
    logic signed [CMP_W-1:0]  dist_next  [PLANES];
    logic signed [CMP_W-1:0]  rad_next   [PLANES];
    logic signed [CMP_W-1:0]  lim_next   [PLANES];
    logic [PLANES-1:0]        out_flag_reg, cross_flag_reg;
    logic [PLANES-1:0]        out_flag_next, cross_flag_next;
    afc_result_t              result_reg, result_next;

    logic accept;

    // The pipeline never holds off a request.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Plane register writes; indexes beyond the plane count are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PLANES; p++)
            begin
                plane_reg[p] <= '0;
            end
        end
        else if (wr_en && (int'(wr_index) < PLANES))
        begin
            plane_reg[wr_index] <= wr_data;
        end
    end

    // Valid bits travel with the data through every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            done_reg     <= s4_valid_reg;
        end
    end

    // Stage 2 products: normal times center, and |normal| times extent.
    always_comb
    begin
        logic signed [COORD_WIDTH-1:0] ctr [3];
        logic        [COORD_WIDTH-2:0] ext [3];
        logic signed [NORM_W-1:0]      nrm;
        logic        [NORM_W-1:0]      nabs;
        ctr[0] = box_reg.box_center_x;
        ctr[1] = box_reg.box_center_y;
        ctr[2] = box_reg.box_center_z;
        ext[0] = box_reg.box_extent_x;
        ext[1] = box_reg.box_extent_y;
        ext[2] = box_reg.box_extent_z;
        for (int p = 0; p < PLANES; p++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                nrm  = signed'(plane_reg[p][NORM_W*a +: NORM_W]);
                nabs = nrm[NORM_W-1] ? NORM_W'(-nrm) : NORM_W'(nrm);
                dprod_next[p][a] = PROD_W'(ctr[a] * nrm);
                rprod_next[p][a] = signed'(PROD_W'(ext[a] * nabs));
            end
        end
    end

    // Stage 3 sums: center distance, radius and the scaled, negated offset.
    always_comb
    begin
        logic signed [NORM_W-1:0] ofs;
        logic signed [CMP_W-1:0]  ofs_ext;
        for (int p = 0; p < PLANES; p++)
        begin
            dist_next[p] = CMP_W'(dprod_reg[p][0]) + CMP_W'(dprod_reg[p][1])
                         + CMP_W'(dprod_reg[p][2]);
            rad_next[p]  = CMP_W'(rprod_reg[p][0]) + CMP_W'(rprod_reg[p][1])
                         + CMP_W'(rprod_reg[p][2]);
            ofs          = signed'(plane_reg[p][PLANE_W-1 -: NORM_W]);
            ofs_ext      = CMP_W'(ofs);
            lim_next[p]  = -(ofs_ext <<< NORMAL_FRAC_BITS);
        end
    end

    // Stage 4 compares against each plane.
    always_comb
    begin
        for (int p = 0; p < PLANES; p++)
        begin
            out_flag_next[p]   = (dist_reg[p] + rad_reg[p]) < lim_reg[p];
            cross_flag_next[p] = (dist_reg[p] - rad_reg[p]) < lim_reg[p];
        end
    end

    // Stage 5 merge: outside wins over intersects, else inside.
    always_comb
    begin
        result_next.visible = !(|out_flag_reg);
        if (|out_flag_reg)
        begin
            result_next.cull_class = CLASS_OUTSIDE;
        end
        else if (|cross_flag_reg)
        begin
            result_next.cull_class = CLASS_INTERSECTS;
        end
        else
        begin
            result_next.cull_class = CLASS_INSIDE;
        end
    end

    // Payload registers of all stages.
    always_ff @(posedge clk)
    begin
        box_reg        <= box;
        dprod_reg      <= dprod_next;
        rprod_reg      <= rprod_next;
        dist_reg       <= dist_next;
        rad_reg        <= rad_next;
        lim_reg        <= lim_next;
        out_flag_reg   <= out_flag_next;
        cross_flag_reg <= cross_flag_next;
        result_reg     <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every request taken gives a result at the end of the pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done)
        else $error("request produced no result after five cycles");

    // No result appears without a matching earlier request.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 5))
        else $error("result without a matching request");

    // The visible flag agrees with the class.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.visible == (result.cull_class != CLASS_OUTSIDE)))
        else $error("visible flag disagrees with cull class");

endmodule

`default_nettype wire

### tb/sv/aabb_frustum_cull_test_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test_tb
// Self-checking bench for the box versus frustum culling test. A scoreboard
// keeps its own copy of the six plane registers, classifies every box taken
// by the block with exact 64-bit arithmetic and compares each result, field
// by field, with the oldest prediction. Plane sets cycle through axis-aligned
// frustums, tilted planes, raw register patterns and field extremes, while
// boxes arrive in random bursts.
// ----------------------------------------------------------------------------

module aabb_frustum_cull_test_tb;
    import afc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 12;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_BOXES    = 140;
    // Unity normal component in the plane fixed-point format.
    localparam int NORMAL_ONE     = 1 << NORMAL_FRAC_BITS;
    // Register indexes past the last plane; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_HI = 3'd7;

    typedef logic [PLANE_W-1:0] plane_set_t [PLANES];

    // Ways of filling the plane registers for one phase.
    typedef enum int {
        PM_AXIS,
        PM_TILTED,
        PM_RAW,
        PM_EXTREME
    } plane_mode_t;

    // ------------------------------------------------------------------------
    // Scoreboard: plane mirror, cull predictor and queue of pending results.
    // ------------------------------------------------------------------------
    class cull_scoreboard;
        logic [PLANE_W-1:0] planes [PLANES];
        afc_result_t        expected_q [$];
        int                 errors;
        int                 checked;
        int                 n_outside;
        int                 n_inside;
        int                 n_crossing;

        function new();
            foreach (planes[i])
                planes[i] = '0;
            errors     = 0;
            checked    = 0;
            n_outside  = 0;
            n_inside   = 0;
            n_crossing = 0;
        endfunction

        function void write_plane(logic [CFG_IDX_W-1:0] idx, logic [PLANE_W-1:0] data);
            if (idx < PLANES)
                planes[idx] = data;
        endfunction

        // Exact classification of one box against the mirrored planes.
        function afc_result_t classify(afc_box_t b);
            longint      ctr_x, ctr_y, ctr_z;
            longint      ext_x, ext_y, ext_z;
            longint      norm_x, norm_y, norm_z, offset;
            longint      center_dist, reach, bound;
            logic        rejected, crossing;
            afc_result_t r;
            ctr_x    = $signed(b.box_center_x);
            ctr_y    = $signed(b.box_center_y);
            ctr_z    = $signed(b.box_center_z);
            ext_x    = b.box_extent_x;
            ext_y    = b.box_extent_y;
            ext_z    = b.box_extent_z;
            rejected = 1'b0;
            crossing = 1'b0;
            for (int i = 0; i < PLANES; i++)
            begin
                norm_x      = $signed(planes[i][NORM_W-1:0]);
                norm_y      = $signed(planes[i][2*NORM_W-1:NORM_W]);
                norm_z      = $signed(planes[i][3*NORM_W-1:2*NORM_W]);
                offset      = $signed(planes[i][4*NORM_W-1:3*NORM_W]);
                center_dist = ctr_x * norm_x + ctr_y * norm_y + ctr_z * norm_z;
                reach       = ext_x * (norm_x < 0 ? -norm_x : norm_x)
                            + ext_y * (norm_y < 0 ? -norm_y : norm_y)
                            + ext_z * (norm_z < 0 ? -norm_z : norm_z);
                bound       = -(offset * NORMAL_ONE);
                if (center_dist + reach < bound)
                    rejected = 1'b1;
                else if (center_dist - reach < bound)
                    crossing = 1'b1;
            end
            r.visible = !rejected;
            if (rejected)
                r.cull_class = CLASS_OUTSIDE;
            else if (crossing)
                r.cull_class = CLASS_INTERSECTS;
            else
                r.cull_class = CLASS_INSIDE;
            return r;
        endfunction

        function void note_request(afc_box_t b);
            expected_q.push_back(classify(b));
        endfunction

        function void check_result(afc_result_t got);
            afc_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("cull result with no box pending: visible %0d, cull_class %0d",
                       got.visible, got.cull_class);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            case (want.cull_class)
                CLASS_OUTSIDE:    n_outside++;
                CLASS_INSIDE:     n_inside++;
                CLASS_INTERSECTS: n_crossing++;
                default:          ;
            endcase
            if (got.visible !== want.visible)
            begin
                $error("visible: expected %0d, actual %0d", want.visible, got.visible);
                errors++;
            end
            if (got.cull_class !== want.cull_class)
            begin
                $error("cull_class: expected %0d, actual %0d",
                       want.cull_class, got.cull_class);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block under test.
    // ------------------------------------------------------------------------
    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 start    = 1'b0;
    logic                 busy;
    afc_box_t             box      = '0;
    logic                 done;
    afc_result_t          result;
    logic                 wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] wr_index = '0;
    logic [PLANE_W-1:0]   wr_data  = '0;

    cull_scoreboard sb = new();
    int             idle_cycles = 0;
    int             plane_settings = 0;

    always #10 clk = ~clk;

    aabb_frustum_cull_test i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .box      (box),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Observe register writes, accepted requests and results at each edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (wr_en)
                sb.write_plane(wr_index, wr_data);
            if (start && !busy)
                sb.note_request(box);
            if (done)
                sb.check_result(result);
            if (wr_en || (start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Stop a hung run.
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic logic [PLANE_W-1:0] pack_plane(int nx, int ny, int nz, int w);
        logic [NORM_W-1:0] fx, fy, fz, fw;
        fx = nx[NORM_W-1:0];
        fy = ny[NORM_W-1:0];
        fz = nz[NORM_W-1:0];
        fw = w[NORM_W-1:0];
        return {fw, fz, fy, fx};
    endfunction

    function automatic afc_box_t pack_box(int cx, int cy, int cz, int ex, int ey, int ez);
        afc_box_t b;
        b.box_center_x = cx[COORD_WIDTH-1:0];
        b.box_center_y = cy[COORD_WIDTH-1:0];
        b.box_center_z = cz[COORD_WIDTH-1:0];
        b.box_extent_x = ex[COORD_WIDTH-2:0];
        b.box_extent_y = ey[COORD_WIDTH-2:0];
        b.box_extent_z = ez[COORD_WIDTH-2:0];
        return b;
    endfunction

    // A quarter of the boxes are raw bit patterns, the rest sit around the
    // frustum at the phase's scale so that all three classes come up.
    function automatic afc_box_t random_box(int scale);
        logic [95:0] raw;
        int          s;
        if ($urandom_range(0, 3) == 0)
        begin
            raw = {$urandom, $urandom, $urandom};
            return raw[$bits(afc_box_t)-1:0];
        end
        s = ($urandom_range(0, 1) != 0) ? scale : scale / 8 + 1;
        return pack_box(int'($urandom_range(0, 2 * s)) - s,
                        int'($urandom_range(0, 2 * s)) - s,
                        int'($urandom_range(0, 2 * s)) - s,
                        $urandom_range(0, s / 2),
                        $urandom_range(0, s / 2),
                        $urandom_range(0, s / 2));
    endfunction

    function automatic int extreme_field();
        case ($urandom_range(0, 3))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    function automatic plane_set_t make_planes(plane_mode_t mode, int scale);
        plane_set_t p;
        for (int i = 0; i < PLANES; i++)
        begin
            case (mode)
                PM_AXIS:
                begin
                    // Axis-aligned cube of half-size scale: planes face inward.
                    p[i] = pack_plane((i == 0) ? NORMAL_ONE : (i == 1) ? -NORMAL_ONE : 0,
                                      (i == 2) ? NORMAL_ONE : (i == 3) ? -NORMAL_ONE : 0,
                                      (i == 4) ? NORMAL_ONE : (i == 5) ? -NORMAL_ONE : 0,
                                      scale);
                end
                PM_TILTED:
                    p[i] = pack_plane(int'($urandom_range(0, 2 * NORMAL_ONE)) - NORMAL_ONE,
                                      int'($urandom_range(0, 2 * NORMAL_ONE)) - NORMAL_ONE,
                                      int'($urandom_range(0, 2 * NORMAL_ONE)) - NORMAL_ONE,
                                      $urandom_range(0, scale));
                PM_RAW:
                    p[i] = {$urandom, $urandom};
                default:
                    p[i] = pack_plane(extreme_field(), extreme_field(),
                                      extreme_field(), extreme_field());
            endcase
        end
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Driver tasks.
    // ------------------------------------------------------------------------
    // Present one box request and hold it until the block takes it.
    task automatic send_box(input afc_box_t b);
        start <= 1'b1;
        box   <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Wait until every predicted result has come back.
    task automatic wait_drained();
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Load all six planes while no box is in flight, plus one dropped write.
    task automatic program_planes(input plane_set_t p);
        start <= 1'b0;
        wait_drained();
        for (int i = 0; i < PLANES; i++)
        begin
            wr_en    <= 1'b1;
            wr_index <= CFG_IDX_W'(i);
            wr_data  <= p[i];
            @(posedge clk);
        end
        wr_en    <= 1'b1;
        wr_index <= ($urandom_range(0, 1) != 0) ? SPARE_INDEX_HI : SPARE_INDEX_LO;
        wr_data  <= {$urandom, $urandom};
        @(posedge clk);
        wr_en <= 1'b0;
        plane_settings++;
    endtask

    // Random boxes in bursts with random gaps; optionally drain midway.
    task automatic run_boxes(input int count, input int scale, input bit no_gaps,
                             input int drain_at);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < count; k++)
            begin
                send_box(random_box(scale));
                sent++;
                if (sent == drain_at)
                begin
                    start <= 1'b0;
                    wait_drained();
                end
            end
            gap = no_gaps ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        plane_set_t  p;
        plane_mode_t mode;
        int          scale;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Planes are all zero after reset, so any box is inside.
        send_box(pack_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(pack_box(-32768, -32768, -32768, 0, 0, 0));
        send_box(pack_box(0, -32768, 32767, 32767, 0, 12345));

        // Cube of half-size 1000: inside, crossing, touching and rejected boxes.
        p = make_planes(PM_AXIS, 1000);
        program_planes(p);
        send_box(pack_box(0, 0, 0, 0, 0, 0));
        send_box(pack_box(0, 0, 0, 2000, 0, 0));
        send_box(pack_box(5000, 0, 0, 10, 10, 10));
        send_box(pack_box(5000, -5000, 5000, 10, 10, 10));
        send_box(pack_box(990, 0, 0, 10, 0, 0));
        send_box(pack_box(990, 0, 0, 11, 0, 0));
        send_box(pack_box(1010, 0, 0, 10, 0, 0));
        send_box(pack_box(1010, 0, 0, 9, 0, 0));

        // Every plane field at its most negative value.
        for (int i = 0; i < PLANES; i++)
            p[i] = pack_plane(-32768, -32768, -32768, -32768);
        program_planes(p);
        send_box(pack_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(pack_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(pack_box(-32768, -32768, -32768, 0, 0, 0));

        // Every plane field at its most positive value.
        for (int i = 0; i < PLANES; i++)
            p[i] = pack_plane(32767, 32767, 32767, 32767);
        program_planes(p);
        send_box(pack_box(-32768, -32768, -32768, 0, 0, 0));
        send_box(pack_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(pack_box(32767, 32767, 32767, 0, 0, 0));

        // Random phases, each with its own plane set and box scale.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            mode = plane_mode_t'(ph % 4);
            case ($urandom_range(0, 3))
                0:       scale = 64;
                1:       scale = 1024;
                2:       scale = 16384;
                default: scale = 32767;
            endcase
            p = make_planes(mode, scale);
            program_planes(p);
            run_boxes(PHASE_BOXES, scale, ph == 6, (ph == 3) ? PHASE_BOXES / 2 : -1);
        end

        // Let the last results come in, then a few quiet cycles.
        start <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d cull results never arrived", sb.pending());
            sb.errors++;
        end

        $display("Checked %0d boxes against %0d plane sets (axis, tilted, raw, extreme).",
                 sb.checked, plane_settings);
        $display("Classes seen: %0d outside, %0d intersecting, %0d inside.",
                 sb.n_outside, sb.n_crossing, sb.n_inside);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
rtl/afc_pkg.sv
rtl/aabb_frustum_cull_test.sv
tb/sv/aabb_frustum_cull_test_tb.sv
